// ----- sv/heartbeat_watchdog_recovery_picker_macros.svh -----
// assertion macros for the heartbeat watchdog recovery picker
// included by the top level only; no other dependencies
`ifndef HEARTBEAT_WATCHDOG_RECOVERY_PICKER_MACROS_SVH
`define HEARTBEAT_WATCHDOG_RECOVERY_PICKER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define HWRP_ASSERT_NOW(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error("hwrp same-cycle check failed");

// next-cycle implication, checked while out of reset
`define HWRP_ASSERT_NEXT(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error("hwrp next-cycle check failed");

`endif

// ----- sv/hwrp_pkg.sv -----
// shared types and constants of the heartbeat watchdog recovery picker
// used by hwrp_csr, hwrp_core and the top level; no dependencies
package hwrp_pkg;

   localparam int CHANNELS   = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // item operation codes
   localparam logic [1:0] OP_HEARTBEAT      = 2'd0;
   localparam logic [1:0] OP_TICK           = 2'd1;
   localparam logic [1:0] OP_RESTART_FAILED = 2'd2;

   // register indexes
   localparam logic [1:0] REG_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_ENGINE   = 2'd1;
   localparam logic [1:0] REG_BRAKING  = 2'd2;
   localparam logic [1:0] REG_STEERING = 2'd3;

   // register reset values
   localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;
   localparam logic [7:0]  ENGINE_RESET   = 8'd30;
   localparam logic [7:0]  BRAKING_RESET  = 8'd80;
   localparam logic [7:0]  STEERING_RESET = 8'd20;

   localparam logic [1:0] CHANNEL_NONE = 2'd0;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] channel_id;
   } req_type;

   typedef struct packed {
      logic [CHANNELS-1:0] new_fail_mask;
      logic                restart_valid;
      logic [1:0]          restart_channel;
      logic [7:0]          restart_priority;
      logic                recovery_verified;
      logic [CHANNELS-1:0] healthy_mask;
   } rsp_type;

   typedef struct packed {
      logic [15:0]              timeout_ms;
      logic [CHANNELS-1:0][7:0] demand;
   } cfg_type;

endpackage

// ----- sv/hwrp_csr.sv -----
// register file of the heartbeat watchdog: timeout and three demand registers
// depends on hwrp_pkg
module hwrp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hwrp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [hwrp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [hwrp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output hwrp_pkg::cfg_type                  cfg
);
   import hwrp_pkg::*;

   logic [15:0] timeout_ff;
   logic [7:0]  engine_ff;
   logic [7:0]  braking_ff;
   logic [7:0]  steering_ff;
   logic [1:0]  reg_index;
   logic        wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         engine_ff   <= ENGINE_RESET;
         braking_ff  <= BRAKING_RESET;
         steering_ff <= STEERING_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_TIMEOUT:  timeout_ff  <= pwdata[15:0];
            REG_ENGINE:   engine_ff   <= pwdata[7:0];
            REG_BRAKING:  braking_ff  <= pwdata[7:0];
            REG_STEERING: steering_ff <= pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TIMEOUT:  prdata = {16'd0, timeout_ff};
         REG_ENGINE:   prdata = {24'd0, engine_ff};
         REG_BRAKING:  prdata = {24'd0, braking_ff};
         REG_STEERING: prdata = {24'd0, steering_ff};
      endcase
   end

   // demand of channel 1 sits in the low byte
   assign cfg = {timeout_ff, steering_ff, braking_ff, engine_ff};

endmodule

// ----- sv/hwrp_core.sv -----
// channel state and single-pass update of the heartbeat watchdog
// depends on hwrp_pkg; result is combinational, registered by the top level
module hwrp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_fire,
   input  hwrp_pkg::req_type item,
   input  hwrp_pkg::cfg_type cfg,
   output hwrp_pkg::rsp_type result
);
   import hwrp_pkg::*;

   typedef enum logic [1:0] {
      ST_NOT_SEEN = 2'd0,
      ST_HEALTHY  = 2'd1,
      ST_FAILED   = 2'd2
   } status_type;

   localparam logic [CHANNELS-1:0][7:0] BASE_PRIO = {8'd40, 8'd50, 8'd30};

   logic [15:0]   count_ff  [CHANNELS];
   logic [15:0]   count_in  [CHANNELS];
   status_type    status_ff [CHANNELS];
   status_type    status_in [CHANNELS];
   logic [CHANNELS-1:0] rec_ff;
   logic [CHANNELS-1:0] rec_in;
   logic [CHANNELS-1:0] rec_mid;
   logic [1:0]    active_ff;
   logic [1:0]    active_in;
   logic [1:0]    active_mid;

   logic [CHANNELS-1:0][7:0] prio;
   logic [CHANNELS-1:0] fail_mask;
   logic [CHANNELS-1:0] healthy;
   logic          verified;
   logic          found;
   logic [7:0]    best;
   logic [1:0]    best_id;

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         prio[k] = BASE_PRIO[k] + {1'b0, cfg.demand[k][7:1]};
      end
   end

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         count_in[k]  = count_ff[k];
         status_in[k] = status_ff[k];
      end
      rec_mid    = rec_ff;
      active_mid = active_ff;
      verified   = 1'b0;
      fail_mask  = '0;
      healthy    = '0;
      found      = 1'b0;
      best       = '0;
      best_id    = CHANNEL_NONE;

      // event of the item
      unique case (item.op)
         OP_HEARTBEAT: begin
            for (int k = 0; k < CHANNELS; k++) begin
               if (item.channel_id == 2'(k + 1)) begin
                  status_in[k] = ST_HEALTHY;
                  count_in[k]  = '0;
                  if (rec_ff[k] && active_ff == 2'(k + 1)) begin
                     verified   = 1'b1;
                     rec_mid[k] = 1'b0;
                     active_mid = CHANNEL_NONE;
                  end
               end
            end
         end
         OP_TICK: begin
            for (int k = 0; k < CHANNELS; k++) begin
               if (count_ff[k] != '1) begin
                  count_in[k] = count_ff[k] + 16'd1;
               end
            end
         end
         OP_RESTART_FAILED: begin
            for (int k = 0; k < CHANNELS; k++) begin
               if (active_ff == 2'(k + 1)) begin
                  rec_mid[k] = 1'b0;
               end
            end
            active_mid = CHANNEL_NONE;
         end
         default: begin
         end
      endcase

      // timeout check
      for (int k = 0; k < CHANNELS; k++) begin
         if (status_in[k] == ST_HEALTHY && count_in[k] > cfg.timeout_ms) begin
            status_in[k] = ST_FAILED;
            fail_mask[k] = 1'b1;
         end
      end

      // pick highest priority failed channel, lower id wins ties
      if (active_mid == CHANNEL_NONE) begin
         for (int k = 0; k < CHANNELS; k++) begin
            if (status_in[k] == ST_FAILED && !rec_mid[k]) begin
               if (!found || prio[k] > best) begin
                  found   = 1'b1;
                  best    = prio[k];
                  best_id = 2'(k + 1);
               end
            end
         end
      end

      rec_in    = rec_mid;
      active_in = active_mid;
      if (found) begin
         active_in = best_id;
         for (int k = 0; k < CHANNELS; k++) begin
            if (best_id == 2'(k + 1)) begin
               rec_in[k] = 1'b1;
            end
         end
      end

      for (int k = 0; k < CHANNELS; k++) begin
         healthy[k] = (status_in[k] == ST_HEALTHY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            count_ff[k]  <= '0;
            status_ff[k] <= ST_NOT_SEEN;
         end
         rec_ff    <= '0;
         active_ff <= CHANNEL_NONE;
      end else if (item_fire) begin
         for (int k = 0; k < CHANNELS; k++) begin
            count_ff[k]  <= count_in[k];
            status_ff[k] <= status_in[k];
         end
         rec_ff    <= rec_in;
         active_ff <= active_in;
      end
   end

   assign result.new_fail_mask     = fail_mask;
   assign result.restart_valid     = found;
   assign result.restart_channel   = best_id;
   assign result.restart_priority  = best;
   assign result.recovery_verified = verified;
   assign result.healthy_mask      = healthy;

endmodule

// ----- sv/heartbeat_watchdog_recovery_picker.sv -----
// an accepted transaction is held in the input register and moves into the result register
// when that register is free or being drained; its result then shows on rsp
// throughput: one transaction per cycle while rsp_stall lets the result register drain, set by
// the single-pass channel update between the input register and the result register
// reset (synchronous, active high) clears all channel state and recovery, empties
// both registers and loads the timeout and demand registers with their defaults
`include "heartbeat_watchdog_recovery_picker_macros.svh"

module heartbeat_watchdog_recovery_picker (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hwrp_pkg::req_type                  req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hwrp_pkg::rsp_type                  rsp_data,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hwrp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [hwrp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [hwrp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import hwrp_pkg::*;

   cfg_type cfg;

   // input register
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   req_type in_data_in;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   rsp_type core_rsp;
   logic    out_load;
   logic    advance;

   // conditions watched by the checks below
   logic    out_restart;
   logic    out_no_restart;
   logic    out_restart_zero;
   logic    out_fail_healthy;

   hwrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the core commits channel state only when its result moves into the
   // result register, so state and results stay in transaction order
   hwrp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (in_data_ff),
      .cfg       (cfg),
      .result    (core_rsp)
   );

   // result register takes a new value when empty or being drained
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   // input register frees up whenever its transaction moves on
   assign req_stall = in_valid_ff && !out_load;

   always_comb begin
      if (req_stall) begin
         in_valid_in = in_valid_ff;
         in_data_in  = in_data_ff;
      end else begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = in_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (advance) begin
         rsp_data_in = core_rsp;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_restart      = rsp_valid_ff && rsp_data_ff.restart_valid;
   assign out_no_restart   = rsp_valid_ff && !rsp_data_ff.restart_valid;
   assign out_restart_zero = (rsp_data_ff.restart_channel == CHANNEL_NONE) &&
                             (rsp_data_ff.restart_priority == 8'd0);
   assign out_fail_healthy = |(rsp_data_ff.new_fail_mask & rsp_data_ff.healthy_mask);

   // an accepted transaction always lands in the input register
   `HWRP_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, in_valid_ff)
   // a requested restart names a real channel
   `HWRP_ASSERT_NOW(a_restart_ch, clock, reset, out_restart, rsp_data.restart_channel != CHANNEL_NONE)
   // no restart means channel and priority read zero
   `HWRP_ASSERT_NOW(a_no_restart_zero, clock, reset, out_no_restart, out_restart_zero)
   // a channel that just failed is never reported healthy
   `HWRP_ASSERT_NOW(a_fail_not_healthy, clock, reset, rsp_valid_ff, !out_fail_healthy)

endmodule

// ----- tb/sv/heartbeat_watchdog_recovery_picker_tb.sv -----
// self-checking testbench for the heartbeat watchdog recovery picker
// depends on hwrp_pkg and heartbeat_watchdog_recovery_picker; reads no files
// directed and random item streams with bursty sender, stalling receiver, apb register port
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hwrp_pkg::*;

   // op code that the block defines as no event
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // per-channel base priority, channel 1 in the low byte
   localparam logic [CHANNELS-1:0][7:0] BASE_PRIORITY = {8'd40, 8'd50, 8'd30};

   // cycles without any accepted transaction before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // long receiver hold-off used to fill the block
   localparam int HOLD_OFF_CYCLES = 300;

   typedef enum logic [1:0] {CH_UNSEEN, CH_HEALTHY, CH_FAILED} chan_status_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic              pready;

   // shadow of the watchdog: configuration
   logic [15:0]              timeout_cfg;
   logic [CHANNELS-1:0][7:0] demand_cfg;

   // shadow of the watchdog: channel state
   logic [15:0]     silence_ticks [CHANNELS];
   chan_status_type chan_state [CHANNELS];
   logic            recovering [CHANNELS];
   logic [1:0]      active_slot;

   // expected result of every accepted request, oldest first
   rsp_type pending_outcomes [$];

   int fail_count;
   int burst_left;
   logic gaps_enabled;
   int hold_request;

   heartbeat_watchdog_recovery_picker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // apply one item to the shadow state and return the result it must produce
   function automatic rsp_type advance_watchdog(req_type item);
      rsp_type    outcome;
      int         k;
      int         best_k;
      logic       found;
      logic [7:0] best;
      logic [7:0] prio;
      outcome = '0;
      found = 1'b0;
      best = '0;
      best_k = 0;

      case (item.op)
         OP_HEARTBEAT: begin
            // channel id zero is ignored
            if (item.channel_id != CHANNEL_NONE) begin
               k = int'(item.channel_id) - 1;
               chan_state[k] = CH_HEALTHY;
               silence_ticks[k] = '0;
               if (recovering[k] && active_slot == item.channel_id) begin
                  outcome.recovery_verified = 1'b1;
                  recovering[k] = 1'b0;
                  active_slot = CHANNEL_NONE;
               end
            end
         end
         OP_TICK: begin
            // every counter counts, seen or not, and sticks at all ones
            for (k = 0; k < CHANNELS; k++) begin
               if (silence_ticks[k] != 16'hFFFF) silence_ticks[k] = silence_ticks[k] + 16'd1;
            end
         end
         OP_RESTART_FAILED: begin
            if (active_slot != CHANNEL_NONE) recovering[int'(active_slot) - 1] = 1'b0;
            active_slot = CHANNEL_NONE;
         end
         default: ;
      endcase

      // timeout check on seen channels only
      for (k = 0; k < CHANNELS; k++) begin
         if (chan_state[k] != CH_UNSEEN && silence_ticks[k] > timeout_cfg &&
             chan_state[k] != CH_FAILED) begin
            chan_state[k] = CH_FAILED;
            outcome.new_fail_mask[k] = 1'b1;
         end
      end

      // pick the highest priority failed channel, lower id wins ties
      if (active_slot == CHANNEL_NONE) begin
         for (k = 0; k < CHANNELS; k++) begin
            if (chan_state[k] == CH_FAILED && !recovering[k]) begin
               prio = BASE_PRIORITY[k] + {1'b0, demand_cfg[k][7:1]};
               if (!found || prio > best) begin
                  found = 1'b1;
                  best = prio;
                  best_k = k;
               end
            end
         end
         if (found) begin
            recovering[best_k] = 1'b1;
            active_slot = 2'(best_k + 1);
            outcome.restart_valid = 1'b1;
            outcome.restart_channel = 2'(best_k + 1);
            outcome.restart_priority = best;
         end
      end

      for (k = 0; k < CHANNELS; k++) begin
         outcome.healthy_mask[k] = (chan_state[k] == CH_HEALTHY);
      end
      return outcome;
   endfunction

   // offer one request transaction; gaps come between bursts of random length
   task automatic send_item(input logic [1:0] op, input logic [1:0] channel);
      req_type item;
      int      gap;
      item.op = op;
      item.channel_id = channel;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = 0;
         if (gaps_enabled && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      // valid high and stall low before the edge means the edge accepts it
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      pending_outcomes.push_back(advance_watchdog(item));
   endtask

   // stop offering and let every outstanding result drain
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb read, compared over the register's width
   task automatic register_read_check(input logic [1:0] index, input logic [31:0] want);
      logic [31:0] mask;
      logic [31:0] got;
      mask = (index == REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if ((got & mask) !== (want & mask)) begin
         fail_count++;
         if (fail_count <= 10)
            $display("register %0d readback: expected %h, got %h", index, want & mask,
                     got & mask);
      end
   endtask

   // apb write, then mirror it in the shadow and read it back
   task automatic register_write(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (index)
         REG_TIMEOUT:  timeout_cfg = value[15:0];
         REG_ENGINE:   demand_cfg[0] = value[7:0];
         REG_BRAKING:  demand_cfg[1] = value[7:0];
         REG_STEERING: demand_cfg[2] = value[7:0];
         default: ;
      endcase
      register_read_check(index, value);
   endtask

   task automatic configure(input logic [15:0] timeout, input logic [7:0] engine,
                            input logic [7:0] braking, input logic [7:0] steering);
      wait_until_idle();
      register_write(REG_TIMEOUT, {16'd0, timeout});
      register_write(REG_ENGINE, {24'd0, engine});
      register_write(REG_BRAKING, {24'd0, braking});
      register_write(REG_STEERING, {24'd0, steering});
   endtask

   // ---------------------------------------------------------------- tests

   // registers come out of reset with their defaults
   task automatic test_register_defaults();
      register_read_check(REG_TIMEOUT, {16'd0, TIMEOUT_RESET});
      register_read_check(REG_ENGINE, {24'd0, ENGINE_RESET});
      register_read_check(REG_BRAKING, {24'd0, BRAKING_RESET});
      register_read_check(REG_STEERING, {24'd0, STEERING_RESET});
   endtask

   // each kind of item and the special cases, zero timeout, extreme demands
   task automatic test_event_kinds();
      configure(16'd0, 8'd255, 8'd0, 8'd255);
      send_item(OP_TICK, CHANNEL_NONE);           // unseen channels count but never fail
      send_item(OP_HEARTBEAT, CHANNEL_NONE);      // heartbeat from channel zero is dropped
      send_item(OP_UNUSED, 2'd3);                 // unused op, only check and selection run
      send_item(OP_RESTART_FAILED, CHANNEL_NONE); // nothing active, nothing happens
      send_item(OP_HEARTBEAT, 2'd1);
      send_item(OP_HEARTBEAT, 2'd2);
      send_item(OP_HEARTBEAT, 2'd3);
      send_item(OP_TICK, CHANNEL_NONE);           // zero timeout, one tick fails all
      send_item(OP_HEARTBEAT, 2'd3);              // verifies the active recovery
      send_item(OP_RESTART_FAILED, 2'd2);         // same channel may be picked again
      send_item(OP_RESTART_FAILED, 2'd1);
      send_item(OP_HEARTBEAT, 2'd2);              // failed but not active, no verify
      send_item(OP_HEARTBEAT, 2'd1);
      send_item(OP_TICK, 2'd3);
   endtask

   // equal priorities on all channels, lower id must win
   task automatic test_priority_ties();
      configure(16'd1, 8'd40, 8'd0, 8'd20);
      send_item(OP_HEARTBEAT, 2'd1);
      send_item(OP_HEARTBEAT, 2'd2);
      send_item(OP_HEARTBEAT, 2'd3);
      send_item(OP_TICK, CHANNEL_NONE);
      send_item(OP_TICK, CHANNEL_NONE);
      send_item(OP_RESTART_FAILED, CHANNEL_NONE);
      send_item(OP_HEARTBEAT, 2'd1);
   endtask

   // largest timeout, no channel can fail after a few ticks
   task automatic test_timeout_extremes();
      configure(16'hFFFF, 8'd0, 8'd255, 8'd0);
      send_item(OP_HEARTBEAT, 2'd1);
      send_item(OP_HEARTBEAT, 2'd2);
      send_item(OP_HEARTBEAT, 2'd3);
      send_item(OP_TICK, CHANNEL_NONE);
      send_item(OP_TICK, CHANNEL_NONE);
   endtask

   // random streams over several settings, biased toward recoveries
   task automatic test_random_traffic();
      int         phase;
      int         n;
      int         pick;
      logic [15:0] timeout;
      logic [1:0]  channel;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: timeout = 16'd0;
            1: timeout = 16'd1;
            5: timeout = 16'hFFFF;
            default: timeout = 16'($urandom_range(2, 6));
         endcase
         // sender idles in some phases, runs flat out in others
         gaps_enabled = (phase % 2 == 0);
         if (phase < 2)
            configure(timeout, phase == 0 ? 8'd255 : 8'd0, phase == 0 ? 8'd0 : 8'd255,
                      8'($urandom_range(0, 255)));
         else
            configure(timeout, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         for (n = 0; n < 115; n++) begin
            pick = $urandom_range(0, 99);
            channel = 2'($urandom_range(1, 3));
            if (pick < 40)
               send_item(OP_TICK, 2'($urandom_range(0, 3)));
            else if (pick < 55)
               // heartbeat from the channel under recovery when there is one
               send_item(OP_HEARTBEAT, active_slot != CHANNEL_NONE ? active_slot : channel);
            else if (pick < 75)
               send_item(OP_HEARTBEAT, channel);
            else if (pick < 80)
               send_item(OP_HEARTBEAT, CHANNEL_NONE);
            else if (pick < 92)
               send_item(OP_RESTART_FAILED, 2'($urandom_range(0, 3)));
            else
               send_item(OP_UNUSED, 2'($urandom_range(0, 3)));
         end
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      int n;
      configure(16'd2, 8'd100, 8'd60, 8'd200);
      gaps_enabled = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      for (n = 0; n < 40; n++) begin
         if (n % 3 == 0)
            send_item(OP_HEARTBEAT, 2'($urandom_range(1, 3)));
         else
            send_item(OP_TICK, CHANNEL_NONE);
      end
      gaps_enabled = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      int k;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      fail_count = 0;
      burst_left = 0;
      gaps_enabled = 1'b1;
      hold_request = 0;
      // shadow starts from the reset state of the block
      timeout_cfg = TIMEOUT_RESET;
      demand_cfg = {STEERING_RESET, BRAKING_RESET, ENGINE_RESET};
      for (k = 0; k < CHANNELS; k++) begin
         silence_ticks[k] = '0;
         chan_state[k] = CH_UNSEEN;
         recovering[k] = 1'b0;
      end
      active_slot = CHANNEL_NONE;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_event_kinds();
      test_priority_ties();
      test_timeout_extremes();
      test_random_traffic();
      test_backpressure();

      // drain, then give stray results time to show up
      wait_until_idle();
      repeat (6) @(posedge clock);
      if (pending_outcomes.size() != 0) fail_count += pending_outcomes.size();

      if (fail_count == 0)
         $display("PASS heartbeat_watchdog_recovery_picker");
      else
         $display("FAIL heartbeat_watchdog_recovery_picker");
      $finish;
   end

   // receiver stall pattern, picks a new random style when the current one runs out
   initial begin
      stall_style_type stall_style;
      int              style_left;
      int              hold_left;
      int              pattern_phase;
      stall_style = STALL_NONE;
      style_left = 0;
      hold_left = 0;
      pattern_phase = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 80);
         end
         style_left--;
         pattern_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
               STALL_HEAVY: rsp_stall <= 1'($urandom_range(0, 1));
               default:     rsp_stall <= (pattern_phase % 3 == 0);
            endcase
         end
      end
   end

   // result checker, looks at the channel at the falling edge before the accepting edge
   initial begin
      rsp_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result transaction with nothing outstanding: %h", rsp_data);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_data.new_fail_mask !== want.new_fail_mask ||
                   rsp_data.restart_valid !== want.restart_valid ||
                   rsp_data.restart_channel !== want.restart_channel ||
                   rsp_data.restart_priority !== want.restart_priority ||
                   rsp_data.recovery_verified !== want.recovery_verified ||
                   rsp_data.healthy_mask !== want.healthy_mask) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch fail/rv/ch/prio/ver/healthy: expected ",
                               "%b %b %0d %0d %b %b, got %b %b %0d %0d %b %b"},
                              want.new_fail_mask, want.restart_valid,
                              want.restart_channel, want.restart_priority,
                              want.recovery_verified, want.healthy_mask,
                              rsp_data.new_fail_mask, rsp_data.restart_valid,
                              rsp_data.restart_channel, rsp_data.restart_priority,
                              rsp_data.recovery_verified, rsp_data.healthy_mask);
               end
            end
         end
      end
   end

   // hang detector, counts cycles in which neither channel moves a transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL heartbeat_watchdog_recovery_picker");
      $finish;
   end

endmodule
